// ----- src/grid_offset_to_partition_core_macros.svh -----
// assertion macros shared by the grid offset to partition block
// expects clk_i and rst_ni in the scope of each use
`ifndef GRID_OFFSET_TO_PARTITION_CORE_MACROS_SVH
`define GRID_OFFSET_TO_PARTITION_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define GOTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define GOTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/gotp_pkg.sv -----
// shared widths, codes and controller/datapath bundles for the tiling index block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gotp_pkg;

  // field widths
  localparam int POINT_W      = 31;
  localparam int SIDE_W       = 16;
  localparam int DIMS_W       = 3;
  localparam int ACC_W        = 32;
  localparam int MAX_DIMS_DEF = 4;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_DIMS = 2'd0;
  localparam logic [1:0] REG_GRID = 2'd1;
  localparam logic [1:0] REG_TILE = 2'd2;

  // register reset values
  localparam logic [DIMS_W-1:0] DIMS_RST = 3'd1;
  localparam logic [SIDE_W-1:0] GRID_RST = 16'd16;
  localparam logic [SIDE_W-1:0] TILE_RST = 16'd4;

  // which division the shared divider runs
  typedef enum logic [1:0] {
    DIV_TPS  = 2'd0,
    DIV_GRID = 2'd1,
    DIV_TILE = 2'd2
  } div_sel_e;

  // which product / update the multiplier step performs
  typedef enum logic [1:0] {
    MUL_IDX     = 2'd0,
    MUL_OFF     = 2'd1,
    MUL_TILE_W  = 2'd2,
    MUL_INNER_W = 2'd3
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     div_cap;
    div_sel_e div_sel;
    logic     mul_go;
    logic     acc;
    mul_sel_e mul_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic cfg_zero;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- src/gotp_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on gotp_pkg
`timescale 1ns / 1ps
`default_nettype none

module gotp_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         short_i,
  input  logic [gotp_pkg::POINT_W-1:0] dividend_i,
  input  logic [gotp_pkg::SIDE_W-1:0]  divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [gotp_pkg::POINT_W-1:0] quot_o,
  output logic [gotp_pkg::SIDE_W-1:0]  rem_o
);
  import gotp_pkg::*;

  localparam int CNT_W = $clog2(POINT_W + 1);

  logic [POINT_W-1:0] q_q, q_d;
  logic [SIDE_W-1:0]  r_q, r_d;
  logic [SIDE_W-1:0]  d_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [SIDE_W:0]    shifted;
  logic [SIDE_W:0]    diff;
  logic               ge;

  // one shift-and-subtract step
  assign shifted = {r_q, q_q[POINT_W-1]};
  assign ge      = (shifted >= {1'b0, d_q});
  assign diff    = shifted - {1'b0, d_q};

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // narrow operands are left-aligned so their top bit comes out first
      q_d    = short_i ? {dividend_i[SIDE_W-1:0], {(POINT_W-SIDE_W){1'b0}}} : dividend_i;
      r_d    = '0;
      cnt_d  = short_i ? CNT_W'(SIDE_W) : CNT_W'(POINT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      q_d   = {q_q[POINT_W-2:0], ge};
      r_d   = ge ? diff[SIDE_W-1:0] : shifted[SIDE_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    if (start_i) begin
      d_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

// ----- src/gotp_dp.sv -----
// datapath: working registers, shared divider, shared multiplier, result register
// depends on gotp_pkg and gotp_div
`timescale 1ns / 1ps
`default_nettype none

module gotp_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gotp_pkg::cmd_t               cmd_i,
  output gotp_pkg::status_t            status_o,
  input  logic [gotp_pkg::SIDE_W-1:0]  grid_side_i,
  input  logic [gotp_pkg::SIDE_W-1:0]  tile_side_i,
  input  logic [gotp_pkg::POINT_W-1:0] point_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [gotp_pkg::POINT_W-1:0] tile_index_o,
  output logic [gotp_pkg::POINT_W-1:0] tile_offset_o
);
  import gotp_pkg::*;

  logic [POINT_W-1:0]      rem_q;
  logic [SIDE_W-1:0]       coord_q;
  logic [SIDE_W-1:0]       tcoord_q;
  logic [SIDE_W-1:0]       icoord_q;
  logic [SIDE_W-1:0]       tps_q;
  logic [ACC_W-1:0]        tile_w_q;
  logic [ACC_W-1:0]        inner_w_q;
  logic [ACC_W-1:0]        idx_acc_q;
  logic [ACC_W-1:0]        off_acc_q;
  logic [ACC_W-1:0]        prod_q;
  logic [POINT_W-1:0]      tile_index_q;
  logic [POINT_W-1:0]      tile_offset_q;
  logic                    out_valid_q;

  logic                    div_short;
  logic [POINT_W-1:0]      div_dividend;
  logic [SIDE_W-1:0]       div_divisor;
  logic                    div_busy;
  logic                    div_done;
  logic [POINT_W-1:0]      div_quot;
  logic [SIDE_W-1:0]       div_rem;

  logic [ACC_W-1:0]        mul_a;
  logic [SIDE_W-1:0]       mul_b;
  logic [ACC_W+SIDE_W-1:0] prod_full;

  // divider operand selection
  always_comb begin
    case (cmd_i.div_sel)
      DIV_TPS: begin
        div_short    = 1'b1;
        div_dividend = POINT_W'(grid_side_i);
        div_divisor  = tile_side_i;
      end
      DIV_GRID: begin
        div_short    = 1'b0;
        div_dividend = rem_q;
        div_divisor  = grid_side_i;
      end
      DIV_TILE: begin
        div_short    = 1'b1;
        div_dividend = POINT_W'(coord_q);
        div_divisor  = tile_side_i;
      end
      default: begin
        div_short    = 1'b1;
        div_dividend = '0;
        div_divisor  = tile_side_i;
      end
    endcase
  end

  gotp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .short_i    (div_short),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // multiplier operand selection, weight times a 16-bit factor
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_IDX: begin
        mul_a = tile_w_q;
        mul_b = tcoord_q;
      end
      MUL_OFF: begin
        mul_a = inner_w_q;
        mul_b = icoord_q;
      end
      MUL_TILE_W: begin
        mul_a = tile_w_q;
        mul_b = tps_q;
      end
      MUL_INNER_W: begin
        mul_a = inner_w_q;
        mul_b = tile_side_i;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q     <= point_i;
      idx_acc_q <= '0;
      off_acc_q <= '0;
      tile_w_q  <= ACC_W'(1);
      inner_w_q <= ACC_W'(1);
    end
    // capture divider results into the register set the division belongs to
    if (cmd_i.div_cap) begin
      case (cmd_i.div_sel)
        DIV_TPS: begin
          tps_q <= div_quot[SIDE_W-1:0];
        end
        DIV_GRID: begin
          rem_q   <= div_quot;
          coord_q <= div_rem;
        end
        DIV_TILE: begin
          tcoord_q <= div_quot[SIDE_W-1:0];
          icoord_q <= div_rem;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.mul_go) begin
      prod_q <= prod_full[ACC_W-1:0];
    end
    // apply the registered product, sums wrap at 32 bits
    if (cmd_i.acc) begin
      case (cmd_i.mul_sel)
        MUL_IDX:     idx_acc_q <= idx_acc_q + prod_q;
        MUL_OFF:     off_acc_q <= off_acc_q + prod_q;
        MUL_TILE_W:  tile_w_q  <= prod_q;
        MUL_INNER_W: inner_w_q <= prod_q;
        default: begin
        end
      endcase
    end
    if (cmd_i.out_load) begin
      tile_index_q  <= idx_acc_q[POINT_W-1:0];
      tile_offset_q <= off_acc_q[POINT_W-1:0];
    end
  end

  // result beat valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.div_busy = div_busy;
  assign status_o.cfg_zero = (grid_side_i == '0) || (tile_side_i == '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign tile_index_o  = tile_index_q;
  assign tile_offset_o = tile_offset_q;

endmodule

`default_nettype wire

// ----- src/gotp_ctrl.sv -----
// controller: sequences the divides and multiply steps for one beat at a time
// depends on gotp_pkg
`timescale 1ns / 1ps
`default_nettype none

module gotp_ctrl #(
  parameter int MaxDims = gotp_pkg::MAX_DIMS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [gotp_pkg::DIMS_W-1:0] dims_i,
  input  gotp_pkg::status_t           status_i,
  output gotp_pkg::cmd_t              cmd_o
);
  import gotp_pkg::*;

  localparam int DIM_W = $clog2(MaxDims + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TPS_GO = 4'd1;
  localparam logic [3:0] S_TPS_WT = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_DG_GO  = 4'd4;
  localparam logic [3:0] S_DG_WT  = 4'd5;
  localparam logic [3:0] S_DT_GO  = 4'd6;
  localparam logic [3:0] S_DT_WT  = 4'd7;
  localparam logic [3:0] S_MUL    = 4'd8;
  localparam logic [3:0] S_ACC    = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [DIM_W-1:0] dim_cnt_q, dim_cnt_d;
  mul_sel_e         mul_sel_q, mul_sel_d;
  logic [DIM_W-1:0] ndims;

  // dimension count saturates at the configured maximum
  assign ndims = (int'(dims_i) > MaxDims) ? DIM_W'(MaxDims) : DIM_W'(dims_i);

  always_comb begin
    state_d   = state_q;
    dim_cnt_d = dim_cnt_q;
    mul_sel_d = mul_sel_q;

    cmd_o           = '0;
    cmd_o.div_sel   = DIV_TPS;
    cmd_o.mul_sel   = mul_sel_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          dim_cnt_d  = '0;
          mul_sel_d  = MUL_IDX;
          // zero side: nothing to divide, accumulators stay zero
          state_d    = status_i.cfg_zero ? S_DONE : S_TPS_GO;
        end
      end
      S_TPS_GO: begin
        cmd_o.div_sel   = DIV_TPS;
        cmd_o.div_start = 1'b1;
        state_d         = S_TPS_WT;
      end
      S_TPS_WT: begin
        cmd_o.div_sel = DIV_TPS;
        if (status_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          state_d       = S_CHK;
        end
      end
      S_CHK: begin
        state_d = (dim_cnt_q == ndims) ? S_DONE : S_DG_GO;
      end
      S_DG_GO: begin
        cmd_o.div_sel   = DIV_GRID;
        cmd_o.div_start = 1'b1;
        state_d         = S_DG_WT;
      end
      S_DG_WT: begin
        cmd_o.div_sel = DIV_GRID;
        if (status_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          state_d       = S_DT_GO;
        end
      end
      S_DT_GO: begin
        cmd_o.div_sel   = DIV_TILE;
        cmd_o.div_start = 1'b1;
        state_d         = S_DT_WT;
      end
      S_DT_WT: begin
        cmd_o.div_sel = DIV_TILE;
        if (status_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          mul_sel_d     = MUL_IDX;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_go = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        // four products per dimension, weights updated last
        case (mul_sel_q)
          MUL_IDX: begin
            mul_sel_d = MUL_OFF;
            state_d   = S_MUL;
          end
          MUL_OFF: begin
            mul_sel_d = MUL_TILE_W;
            state_d   = S_MUL;
          end
          MUL_TILE_W: begin
            mul_sel_d = MUL_INNER_W;
            state_d   = S_MUL;
          end
          default: begin
            mul_sel_d = MUL_IDX;
            dim_cnt_d = dim_cnt_q + DIM_W'(1);
            state_d   = S_CHK;
          end
        endcase
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      dim_cnt_q <= '0;
      mul_sel_q <= MUL_IDX;
    end else begin
      state_q   <= state_d;
      dim_cnt_q <= dim_cnt_d;
      mul_sel_q <= mul_sel_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ----- src/grid_offset_to_partition_core.sv -----
// channel     dir  handshake                 payload
// input       in   in_valid_i / in_stall_o   point_i
// output      out  out_valid_o / out_stall_i tile_index_o, tile_offset_o
// config      in   psel/penable/pwrite       paddr, pwdata -> prdata, pready
//
// one beat at a time; a beat runs on the shared one-bit-per-cycle divider
// (31 steps per grid divide, 16 per tile divide) and on the shared multiplier,
// with its multiply/accumulate steps for each dimension.
// a zero grid or tile side skips the divides and multiplies and gives zero results.
// reset clears control state and loads the register reset values; no clearing pass.
// a new beat is taken while a finished result still sits stalled in the output register.
//
// top level: configuration registers, controller and datapath
// depends on gotp_pkg, gotp_ctrl, gotp_dp and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

module grid_offset_to_partition_core #(
  parameter int MaxDims = gotp_pkg::MAX_DIMS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gotp_pkg::POINT_W-1:0]    point_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gotp_pkg::POINT_W-1:0]    tile_index_o,
  output logic [gotp_pkg::POINT_W-1:0]    tile_offset_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gotp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gotp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [gotp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import gotp_pkg::*;

  `include "grid_offset_to_partition_core_macros.svh"

  logic [DIMS_W-1:0] dims_q;
  logic [SIDE_W-1:0] grid_q;
  logic [SIDE_W-1:0] tile_q;
  logic              cfg_wr;
  logic [1:0]        reg_idx;
  cmd_t              cmd;
  status_t           status;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIMS_RST;
      grid_q <= GRID_RST;
      tile_q <= TILE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DIMS: dims_q <= pwdata[DIMS_W-1:0];
        REG_GRID: grid_q <= pwdata[SIDE_W-1:0];
        REG_TILE: tile_q <= pwdata[SIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_DIMS: prdata = CFG_DATA_W'(dims_q);
      REG_GRID: prdata = CFG_DATA_W'(grid_q);
      REG_TILE: prdata = CFG_DATA_W'(tile_q);
      default:  prdata = '0;
    endcase
  end

  gotp_ctrl #(
    .MaxDims (MaxDims)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .dims_i     (dims_q),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gotp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .grid_side_i   (grid_q),
    .tile_side_i   (tile_q),
    .point_i       (point_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .tile_index_o  (tile_index_o),
    .tile_offset_o (tile_offset_o)
  );

  // checks on the sequencing
  `GOTP_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input not stalled")
  `GOTP_ASSERT_IMP(a_div_start_idle, cmd.div_start, !status.div_busy, "divider started while busy")
  `GOTP_ASSERT_IMP(a_out_load_free, cmd.out_load, status.out_free, "stalled result overwritten")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for grid_offset_to_partition_core: points are split into tile index
// and in-tile offset by an in-bench model and compared beat by beat with the block's results
// depends on gotp_pkg and grid_offset_to_partition_core

module testbench;
  import gotp_pkg::*;

  localparam int QuietLimit  = 4000;
  localparam int DrainCycles = 300;
  localparam int MaxReports  = 10;
  localparam int IdlePercent = 36;

  typedef struct packed {
    logic [POINT_W-1:0] index;
    logic [POINT_W-1:0] offset;
  } tile_pos_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [POINT_W-1:0]    point_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [POINT_W-1:0]    tile_index_o;
  logic [POINT_W-1:0]    tile_offset_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr       = '0;
  logic [CFG_DATA_W-1:0] pwdata      = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // bench copy of the configuration registers
  logic [DIMS_W-1:0] dims_q = DIMS_RST;
  logic [SIDE_W-1:0] grid_q = GRID_RST;
  logic [SIDE_W-1:0] tile_q = TILE_RST;

  logic [POINT_W-1:0] points_to_send[$];
  tile_pos_t          due_tiles[$];
  int                 n_queued = 0;
  int                 n_taken  = 0;
  int                 n_errors = 0;
  logic               calm     = 1'b0;
  logic               in_taken = 1'b0;

  grid_offset_to_partition_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .point_i       (point_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tile_index_o  (tile_index_o),
    .tile_offset_o (tile_offset_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // split a point into grid coordinates, then each into tile and in-tile parts
  function automatic tile_pos_t locate_in_tile(input logic [POINT_W-1:0] pt);
    tile_pos_t        res;
    logic [ACC_W-1:0] rest, per_side, tile_w, inner_w, t_idx, t_off, coord;
    int               ndims;
    rest    = {1'b0, pt};
    ndims   = (dims_q > MAX_DIMS_DEF) ? MAX_DIMS_DEF : int'(dims_q);
    t_idx   = '0;
    t_off   = '0;
    tile_w  = 1;
    inner_w = 1;
    if (grid_q != 0 && tile_q != 0) begin
      per_side = grid_q / tile_q;
      for (int d = 0; d < ndims; d++) begin
        coord   = rest % grid_q;
        t_idx   = t_idx + tile_w * (coord / tile_q);
        t_off   = t_off + inner_w * (coord % tile_q);
        rest    = rest / grid_q;
        tile_w  = tile_w * per_side;
        inner_w = inner_w * tile_q;
      end
    end
    res.index  = t_idx[POINT_W-1:0];
    res.offset = t_off[POINT_W-1:0];
    return res;
  endfunction

  // mostly points inside the configured grid, the rest anywhere in the field
  function automatic logic [POINT_W-1:0] pick_point();
    longint span;
    int     ndims;
    span  = 1;
    ndims = (dims_q > MAX_DIMS_DEF) ? MAX_DIMS_DEF : int'(dims_q);
    for (int d = 0; d < ndims; d++) begin
      if (span < 64'h8000_0000) span = span * grid_q;
    end
    if (span > 64'h8000_0000) span = 64'h8000_0000;
    if (span == 0 || $urandom_range(0, 3) == 0) return POINT_W'($urandom);
    return POINT_W'({$urandom, $urandom} % span);
  endfunction

  // one register write: setup cycle, then access until pready
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DIMS: dims_q = value[DIMS_W-1:0];
      REG_GRID: grid_q = value[SIDE_W-1:0];
      REG_TILE: tile_q = value[SIDE_W-1:0];
      default: ;
    endcase
  endtask

  // all three registers, with junk in the unused upper bits
  task automatic set_sides(input logic [31:0] d, input logic [31:0] g, input logic [31:0] t);
    logic [31:0] noise;
    noise = $urandom;
    write_reg(REG_DIMS, {noise[31:DIMS_W], d[DIMS_W-1:0]});
    noise = $urandom;
    write_reg(REG_GRID, {noise[31:SIDE_W], g[SIDE_W-1:0]});
    noise = $urandom;
    write_reg(REG_TILE, {noise[31:SIDE_W], t[SIDE_W-1:0]});
  endtask

  task automatic queue_point(input logic [POINT_W-1:0] pt);
    points_to_send.push_back(pt);
    n_queued++;
  endtask

  // hold until every queued point is taken and every result is back
  task automatic settle();
    while (n_taken != n_queued || due_tiles.size() != 0) @(negedge clk_i);
  endtask

  // input driver: next point on a free or just-taken slot, with random gaps
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (points_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePercent)) begin
        in_valid_i <= 1'b1;
        point_i    <= points_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        point_i    <= POINT_W'($urandom);
      end
    end
    out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePercent);
  end

  // monitor: check result beats against the oldest prediction, predict on input beats
  always @(posedge clk_i) begin
    tile_pos_t want;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_tiles.size() == 0) begin
          n_errors++;
          if (n_errors <= MaxReports)
            $display("unexpected result: index %h offset %h", tile_index_o, tile_offset_o);
        end else begin
          want = due_tiles.pop_front();
          if (tile_index_o !== want.index || tile_offset_o !== want.offset) begin
            n_errors++;
            if (n_errors <= MaxReports)
              $display("mismatch: index exp %h got %h, offset exp %h got %h",
                       want.index, tile_index_o, want.offset, tile_offset_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        due_tiles.push_back(locate_in_tile(point_i));
        n_taken++;
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) quiet = 0;
      else quiet++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    int pick, d, g, t;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset values first, then the corners of the configuration
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: set_sides(0, 16, 4);        // no dimensions in use
        2: set_sides(7, 10, 3);        // dimensions above the maximum
        3: set_sides(4, 0, 4);         // zero grid side
        4: set_sides(4, 100, 0);       // zero tile side
        5: set_sides(3, 5, 9);         // tile wider than the grid
        6: set_sides(4, 65535, 1);     // radix powers wrap
        7: set_sides(2, 65535, 65535); // widest sides
        default: ;
      endcase
      queue_point('0);
      queue_point('1);
      queue_point(POINT_W'($urandom));
      settle();
    end

    // random phases, each with a fresh configuration
    for (int ph = 0; ph < 12; ph++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) d = 0;
      else if (pick == 1) d = $urandom_range(5, 7);
      else d = $urandom_range(1, 4);
      pick = $urandom_range(0, 19);
      if (pick == 0) g = 0;
      else if (pick == 1) g = 65535;
      else if (pick == 2) g = 1;
      else if (pick < 6) g = $urandom_range(256, 65535);
      else g = $urandom_range(2, 64);
      pick = $urandom_range(0, 19);
      if (pick == 0) t = 0;
      else if (pick == 1) t = (g + $urandom_range(1, 200)) & 16'hFFFF;
      else if (pick == 2) t = 1;
      else if (pick == 3) t = g;
      else t = $urandom_range(1, (g > 1) ? g : 1);
      set_sides(d, g, t);
      calm = (ph == 5);
      repeat (75) queue_point(pick_point());
      settle();
    end
    calm = 1'b0;

    repeat (DrainCycles) @(negedge clk_i);
    n_errors += due_tiles.size();
    if (n_errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/gotp_pkg.sv
src/gotp_div.sv
src/gotp_dp.sv
src/gotp_ctrl.sv
src/grid_offset_to_partition_core.sv
tb/testbench.sv
